@@ rtl/dns_query_question_parser_unit_defines.svh @@
// Assertion macros shared by the parser files.
`ifndef DNS_QUERY_QUESTION_PARSER_UNIT_DEFINES_SVH
`define DNS_QUERY_QUESTION_PARSER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DNSQP_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dnsqp check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define DNSQP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dnsqp check failed in the following cycle");

`endif

@@ rtl/dnsqp_pkg.sv @@
package dnsqp_pkg;

  // Longest dotted name that may be produced, dots included.
  localparam int MAX_NAME_LENGTH = 255;

  // Masks applied to the header flag word.
  localparam logic [15:0] QR_MASK      = 16'h8000;
  localparam logic [15:0] AA_MASK      = 16'h0400;
  localparam logic [15:0] TC_MASK      = 16'h0200;
  localparam logic [15:0] RD_MASK      = 16'h0100;
  localparam logic [15:0] RA_MASK      = 16'h0080;
  localparam logic [15:0] OPCODE_FIELD = 16'h7800;
  localparam logic [15:0] RCODE_FIELD  = 16'h000F;
  localparam int          OPCODE_LSB   = 11;

  localparam logic [7:0] DOT_CHAR = 8'h2E;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_HEADER    = 3'd0,
    KIND_CHAR      = 3'd1,
    KIND_QDONE     = 3'd2,
    KIND_REJECT    = 3'd3,
    KIND_MALFORMED = 3'd4
  } kind_t;

  // One result item.
  typedef struct packed {
    kind_t       kind;
    logic [15:0] message_id;
    logic [4:0]  flag_bits;
    logic [3:0]  operation_code;
    logic [3:0]  response_code;
    logic [15:0] question_count;
    logic [15:0] additional_count;
    logic [7:0]  name_char;
    logic [15:0] query_type;
    logic [15:0] query_class;
    logic        last_question;
  } result_t;

endpackage

@@ rtl/dnsqp_if.sv @@
// Packet byte channel.
interface dnsqp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       end_of_packet;

  modport source (output valid, output packet_byte, output end_of_packet, input ready);
  modport sink (input valid, input packet_byte, input end_of_packet, output ready);
endinterface

// Result channel.
interface dnsqp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] message_id;
  logic [4:0]  flag_bits;
  logic [3:0]  operation_code;
  logic [3:0]  response_code;
  logic [15:0] question_count;
  logic [15:0] additional_count;
  logic [7:0]  name_char;
  logic [15:0] query_type;
  logic [15:0] query_class;
  logic        last_question;

  modport source (
    output valid, input ready, output kind, output message_id, output flag_bits,
    output operation_code, output response_code, output question_count,
    output additional_count, output name_char, output query_type, output query_class,
    output last_question
  );
  modport sink (
    input valid, output ready, input kind, input message_id, input flag_bits,
    input operation_code, input response_code, input question_count,
    input additional_count, input name_char, input query_type, input query_class,
    input last_question
  );
endinterface

@@ rtl/dnsqp_parser.sv @@
`include "dns_query_question_parser_unit_defines.svh"

// Parse state and the per-byte step logic.
module dnsqp_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         pkt_byte,
  input  logic               eop,
  output logic               res_vld,
  output dnsqp_pkg::result_t res
);

  typedef enum logic [2:0] {
    PH_HEADER     = 3'd0,
    PH_HEADER_BAD = 3'd1,
    PH_LEN        = 3'd2,
    PH_DATA       = 3'd3,
    PH_TYPE       = 3'd4,
    PH_CLASS      = 3'd5
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  byte_pos, byte_pos_next;
  logic [7:0]  held_high, held_high_next;
  logic [15:0] saved_id, saved_id_next;
  logic [15:0] saved_flags, saved_flags_next;
  logic [15:0] questions_left, questions_left_next;
  logic [15:0] saved_additional, saved_additional_next;
  logic [7:0]  label_left, label_left_next;
  logic        first_label, first_label_next;
  logic [8:0]  name_len, name_len_next;
  logic [15:0] saved_qtype, saved_qtype_next;
  logic        skipping, skipping_next;

  logic [15:0] word;
  logic        emit_req;
  logic [7:0]  emit_c;

  assign word = {held_high, pkt_byte};

  // Next state and result for the byte on the input.
  always_comb begin
    phase_next            = phase;
    byte_pos_next         = byte_pos;
    held_high_next        = held_high;
    saved_id_next         = saved_id;
    saved_flags_next      = saved_flags;
    questions_left_next   = questions_left;
    saved_additional_next = saved_additional;
    label_left_next       = label_left;
    first_label_next      = first_label;
    name_len_next         = name_len;
    saved_qtype_next      = saved_qtype;
    skipping_next         = skipping;
    res                   = '0;
    res_vld               = 1'b0;
    emit_req              = 1'b0;
    emit_c                = '0;

    if (!skipping) begin
      unique case (phase)
        PH_HEADER, PH_HEADER_BAD: begin
          if (!byte_pos[0]) begin
            held_high_next = pkt_byte;
            byte_pos_next  = byte_pos + 4'd1;
          end else if (byte_pos == 4'd1) begin
            saved_id_next = word;
            byte_pos_next = byte_pos + 4'd1;
          end else if (byte_pos == 4'd3) begin
            saved_flags_next = word;
            byte_pos_next    = byte_pos + 4'd1;
          end else if (byte_pos == 4'd5) begin
            questions_left_next = word;
            byte_pos_next       = byte_pos + 4'd1;
          end else if (byte_pos == 4'd7 || byte_pos == 4'd9) begin
            // Answer and authority counts must both be zero.
            if (word != 16'd0) begin
              phase_next = PH_HEADER_BAD;
            end
            byte_pos_next = byte_pos + 4'd1;
          end else begin
            // Last header word: report the header.
            saved_additional_next = word;
            byte_pos_next         = '0;
            res_vld               = 1'b1;
            res.message_id        = saved_id;
            res.flag_bits = {(saved_flags & dnsqp_pkg::QR_MASK) != 16'd0,
                             (saved_flags & dnsqp_pkg::AA_MASK) != 16'd0,
                             (saved_flags & dnsqp_pkg::TC_MASK) != 16'd0,
                             (saved_flags & dnsqp_pkg::RD_MASK) != 16'd0,
                             (saved_flags & dnsqp_pkg::RA_MASK) != 16'd0};
            res.operation_code = 4'((saved_flags & dnsqp_pkg::OPCODE_FIELD)
                                    >> dnsqp_pkg::OPCODE_LSB);
            res.response_code    = 4'(saved_flags & dnsqp_pkg::RCODE_FIELD);
            res.question_count   = questions_left;
            res.additional_count = word;
            if (phase == PH_HEADER_BAD) begin
              res.kind      = dnsqp_pkg::KIND_REJECT;
              skipping_next = 1'b1;
            end else begin
              res.kind = dnsqp_pkg::KIND_HEADER;
              if (questions_left == 16'd0) begin
                skipping_next = 1'b1;
              end else begin
                phase_next       = PH_LEN;
                first_label_next = 1'b1;
                name_len_next    = '0;
                label_left_next  = '0;
              end
            end
          end
        end
        PH_LEN: begin
          if (pkt_byte == 8'd0) begin
            phase_next    = PH_TYPE;
            byte_pos_next = '0;
          end else begin
            label_left_next = pkt_byte;
            phase_next      = PH_DATA;
            if (!first_label) begin
              emit_req = 1'b1;
              emit_c   = dnsqp_pkg::DOT_CHAR;
            end
            first_label_next = 1'b0;
          end
        end
        PH_DATA: begin
          emit_req        = 1'b1;
          emit_c          = pkt_byte;
          label_left_next = label_left - 8'd1;
          if (label_left == 8'd1) begin
            phase_next = PH_LEN;
          end
        end
        PH_TYPE: begin
          if (!byte_pos[0]) begin
            held_high_next = pkt_byte;
            byte_pos_next  = 4'd1;
          end else begin
            saved_qtype_next = word;
            phase_next       = PH_CLASS;
            byte_pos_next    = '0;
          end
        end
        PH_CLASS: begin
          if (!byte_pos[0]) begin
            held_high_next = pkt_byte;
            byte_pos_next  = 4'd1;
          end else begin
            res_vld             = 1'b1;
            res.kind            = dnsqp_pkg::KIND_QDONE;
            res.query_type      = saved_qtype;
            res.query_class     = word;
            res.last_question   = (questions_left == 16'd1);
            byte_pos_next       = '0;
            questions_left_next = questions_left - 16'd1;
            if (questions_left == 16'd1) begin
              skipping_next = 1'b1;
            end else begin
              phase_next       = PH_LEN;
              first_label_next = 1'b1;
              name_len_next    = '0;
              label_left_next  = '0;
            end
          end
        end
        default: begin
          skipping_next = 1'b1;
        end
      endcase
    end

    // A name character, or malformed once the name limit is reached.
    if (emit_req) begin
      res_vld = 1'b1;
      if (name_len >= 9'(dnsqp_pkg::MAX_NAME_LENGTH)) begin
        res.kind      = dnsqp_pkg::KIND_MALFORMED;
        skipping_next = 1'b1;
      end else begin
        res.kind      = dnsqp_pkg::KIND_CHAR;
        res.name_char = emit_c;
        name_len_next = name_len + 9'd1;
      end
    end

    // The end of the packet: a packet cut short is malformed, then start afresh.
    if (eop) begin
      if (!skipping_next) begin
        res      = '0;
        res.kind = dnsqp_pkg::KIND_MALFORMED;
        res_vld  = 1'b1;
      end
      phase_next            = PH_HEADER;
      byte_pos_next         = '0;
      held_high_next        = '0;
      saved_id_next         = '0;
      saved_flags_next      = '0;
      questions_left_next   = '0;
      saved_additional_next = '0;
      label_left_next       = '0;
      first_label_next      = 1'b1;
      name_len_next         = '0;
      saved_qtype_next      = '0;
      skipping_next         = 1'b0;
    end
  end

  // State registers, advanced once per processed byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      byte_pos         <= '0;
      held_high        <= '0;
      saved_id         <= '0;
      saved_flags      <= '0;
      questions_left   <= '0;
      saved_additional <= '0;
      label_left       <= '0;
      first_label      <= 1'b1;
      name_len         <= '0;
      saved_qtype      <= '0;
      skipping         <= 1'b0;
    end else if (step) begin
      phase            <= phase_next;
      byte_pos         <= byte_pos_next;
      held_high        <= held_high_next;
      saved_id         <= saved_id_next;
      saved_flags      <= saved_flags_next;
      questions_left   <= questions_left_next;
      saved_additional <= saved_additional_next;
      label_left       <= label_left_next;
      first_label      <= first_label_next;
      name_len         <= name_len_next;
      saved_qtype      <= saved_qtype_next;
      skipping         <= skipping_next;
    end
  end

  // A processed end-of-packet byte leaves the parser ready for a new header.
  `DNSQP_ASSERT_NEXT(a_eop_restart, clk, rst, step && eop,
                     phase == PH_HEADER && byte_pos == 4'd0 && !skipping)
  // While a question is being parsed, at least one question is still owed.
  `DNSQP_ASSERT_SAME(a_question_owed, clk, rst,
                     !skipping && (phase == PH_LEN || phase == PH_DATA ||
                                   phase == PH_TYPE || phase == PH_CLASS),
                     questions_left != 16'd0)
  // The dotted name never grows past the limit.
  `DNSQP_ASSERT_SAME(a_name_limit, clk, rst, 1'b1,
                     name_len <= 9'(dnsqp_pkg::MAX_NAME_LENGTH))
  // A label in progress always has bytes left to read.
  `DNSQP_ASSERT_SAME(a_label_nonzero, clk, rst, !skipping && phase == PH_DATA,
                     label_left != 8'd0)

endmodule

@@ rtl/dns_query_question_parser_unit.sv @@
// DNS query header and question parser.
//
// The packet channel takes one packet byte per item, with end_of_packet set
// on the final byte. The result channel gives at most one item per byte: the
// unpacked header, a rejection, one dotted name character, a finished
// question with its type and class, or a malformed-packet report.
// Throughput is one byte per cycle while the result receiver keeps ready
// high. A byte is captured in the input register, then parsed into the
// result register once that register is free or being emptied. When the
// receiver stalls with a result waiting, one more byte is still taken into
// the input register; after that the packet channel holds ready low until
// the result is taken.
// Synchronous reset empties both registers and returns the parser to the
// start of a header.
module dns_query_question_parser_unit (
  input  logic clk,
  input  logic rst,
  dnsqp_in_if.sink    packet,
  dnsqp_out_if.source result
);

  logic               s1_vld;
  logic [7:0]         s1_byte;
  logic               s1_eop;
  logic               advance;
  logic               step_vld;
  dnsqp_pkg::result_t step_res;
  logic               out_vld;
  dnsqp_pkg::result_t out_q;

  // A buffered byte is parsed whenever the result register is free or emptying.
  assign advance      = s1_vld && (!out_vld || result.ready);
  assign packet.ready = !s1_vld || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (packet.ready) begin
      s1_vld <= packet.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (packet.valid && packet.ready) begin
      s1_byte <= packet.packet_byte;
      s1_eop  <= packet.end_of_packet;
    end
  end

  dnsqp_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .pkt_byte (s1_byte),
    .eop      (s1_eop),
    .res_vld  (step_vld),
    .res      (step_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= step_vld;
    end else if (result.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_vld) begin
      out_q <= step_res;
    end
  end

  assign result.valid            = out_vld;
  assign result.kind             = out_q.kind;
  assign result.message_id       = out_q.message_id;
  assign result.flag_bits        = out_q.flag_bits;
  assign result.operation_code   = out_q.operation_code;
  assign result.response_code    = out_q.response_code;
  assign result.question_count   = out_q.question_count;
  assign result.additional_count = out_q.additional_count;
  assign result.name_char        = out_q.name_char;
  assign result.query_type       = out_q.query_type;
  assign result.query_class      = out_q.query_class;
  assign result.last_question    = out_q.last_question;

endmodule
